// ----- hdl/interp_joint_histogram_core_assert.svh -----
// Assertion macros shared by the histogram core.
// Expects signals named clk and arst_n in the scope of use.
`ifndef INTERP_JOINT_HISTOGRAM_CORE_ASSERT_SVH
`define INTERP_JOINT_HISTOGRAM_CORE_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define IJH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication, disabled during reset.
`define IJH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

// ----- hdl/ijh_pkg.sv -----
// Shared constants, codes and types of the joint histogram core.
// No dependencies.
`timescale 1ns / 1ps
package ijh_pkg;
	localparam int BINS_DEF    = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int COUNT_BITS  = 20;
	localparam int POS_FRAC    = 24;
	localparam int SCALE_W     = 32;
	localparam int NB_W        = 7;
	localparam int RB_W        = 6;
	localparam int OP_W        = 2;
	localparam int MAG_W       = SAMPLE_BITS + SCALE_W;
	localparam int W_W         = FRAC_BITS + 1;
	localparam int P_W         = 2 * W_W;
	localparam int JW          = COUNT_BITS + 2 * FRAC_BITS;
	localparam int MW          = COUNT_BITS + FRAC_BITS;
	localparam int CW          = COUNT_BITS + 1;
	localparam int PADDR_W     = 4;

	localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] REG_MIN_INTENSITY = 2'd0;
	localparam logic [1:0] REG_BIN_SCALE     = 2'd1;
	localparam logic [1:0] REG_BINS_IN_USE   = 2'd2;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] min_intensity;
		logic [SCALE_W-1:0]     bin_scale;
		logic [NB_W-1:0]        bins_in_use;
	} cfg_t;

	typedef struct packed {
		logic rd_en;
		logic upd;
		logic clr_en;
	} rmw_ctl_t;
endpackage

// ----- hdl/ijh_if.sv -----
// Valid/ready channel interfaces for the pixel and result words.
// Depends on ijh_pkg.
`timescale 1ns / 1ps
interface ijh_in_if;
	logic                            valid;
	logic                            ready;
	logic [ijh_pkg::OP_W-1:0]        opcode;
	logic [ijh_pkg::SAMPLE_BITS-1:0] sample_a;
	logic [ijh_pkg::SAMPLE_BITS-1:0] sample_b;
	logic [ijh_pkg::RB_W-1:0]        read_bin_a;
	logic [ijh_pkg::RB_W-1:0]        read_bin_b;
	modport source (output valid, opcode, sample_a, sample_b, read_bin_a, read_bin_b,
		input ready);
	modport sink (input valid, opcode, sample_a, sample_b, read_bin_a, read_bin_b,
		output ready);
endinterface

interface ijh_out_if;
	logic                   valid;
	logic                   ready;
	logic [ijh_pkg::JW-1:0] joint_sum;
	logic [ijh_pkg::MW-1:0] marginal_a_sum;
	logic [ijh_pkg::MW-1:0] marginal_b_sum;
	logic [ijh_pkg::CW-1:0] pixel_total;
	modport source (output valid, joint_sum, marginal_a_sum, marginal_b_sum, pixel_total,
		input ready);
	modport sink (input valid, joint_sum, marginal_a_sum, marginal_b_sum, pixel_total,
		output ready);
endinterface

// ----- hdl/ijh_cfg.sv -----
// APB-style register file: minimum intensity, bin scale, bins in use.
// Depends on ijh_pkg.
`timescale 1ns / 1ps
module ijh_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ijh_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output ijh_pkg::cfg_t               cfg
);
	ijh_pkg::cfg_t cfg_q;
	logic          wr;
	logic [1:0]    idx;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[ijh_pkg::PADDR_W-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_intensity <= '0;
			cfg_q.bin_scale     <= 32'd16777216;
			cfg_q.bins_in_use   <= 7'd64;
		end else if (wr) begin
			unique case (idx)
				ijh_pkg::REG_MIN_INTENSITY: cfg_q.min_intensity <= pwdata[15:0];
				ijh_pkg::REG_BIN_SCALE:     cfg_q.bin_scale     <= pwdata;
				ijh_pkg::REG_BINS_IN_USE:   cfg_q.bins_in_use   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ijh_pkg::REG_MIN_INTENSITY: prdata = {16'd0, cfg_q.min_intensity};
			ijh_pkg::REG_BIN_SCALE:     prdata = cfg_q.bin_scale;
			ijh_pkg::REG_BINS_IN_USE:   prdata = {25'd0, cfg_q.bins_in_use};
			default:                    prdata = '0;
		endcase
	end
endmodule

// ----- hdl/ijh_locate.sv -----
// Maps one sample to its two neighbor bins and linear weights, two stages.
// Depends on ijh_pkg.
`timescale 1ns / 1ps
module ijh_locate #(
	parameter int BINS = ijh_pkg::BINS_DEF
) (
	input  logic                            clk,
	input  logic                            load,
	input  ijh_pkg::cfg_t                   cfg,
	input  logic [ijh_pkg::SAMPLE_BITS-1:0] sample,
	output logic [$clog2(BINS)-1:0]         lo_bin,
	output logic [$clog2(BINS)-1:0]         hi_bin,
	output logic [ijh_pkg::W_W-1:0]         w_lo,
	output logic [ijh_pkg::W_W-1:0]         w_hi
);
	localparam int BIN_W = $clog2(BINS);
	localparam int IP_W  = ijh_pkg::MAG_W - ijh_pkg::POS_FRAC;

	logic [ijh_pkg::SAMPLE_BITS:0]   diff;
	logic [ijh_pkg::SAMPLE_BITS-1:0] absd;
	logic [ijh_pkg::MAG_W-1:0]       mag_s1;
	logic                            neg_s1;

	logic                          below;
	logic [ijh_pkg::POS_FRAC-1:0]  frac;
	logic [ijh_pkg::FRAC_BITS-1:0] wh;
	logic [IP_W-1:0]               lo_pos;
	logic [IP_W:0]                 hi_pos;
	logic [8:0]                    nb;
	logic [BIN_W-1:0]              nbm1;

	assign diff = {1'b0, sample} - {1'b0, cfg.min_intensity};
	assign absd = diff[ijh_pkg::SAMPLE_BITS] ? ijh_pkg::SAMPLE_BITS'(-diff)
		: diff[ijh_pkg::SAMPLE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (load) begin
			mag_s1 <= ijh_pkg::MAG_W'(absd) * ijh_pkg::MAG_W'(cfg.bin_scale);
			neg_s1 <= diff[ijh_pkg::SAMPLE_BITS];
		end
	end

	// A negative position with a nonzero magnitude lies left of bin zero.
	always_comb begin
		below  = neg_s1 && (mag_s1 != '0);
		frac   = below ? ijh_pkg::POS_FRAC'(-mag_s1[ijh_pkg::POS_FRAC-1:0])
			: mag_s1[ijh_pkg::POS_FRAC-1:0];
		wh     = frac[ijh_pkg::POS_FRAC-1 -: ijh_pkg::FRAC_BITS];
		lo_pos = below ? '0 : mag_s1[ijh_pkg::MAG_W-1:ijh_pkg::POS_FRAC];
		hi_pos = below ? '0 : ({1'b0, lo_pos} + (IP_W+1)'(1));
		if (cfg.bins_in_use == '0)
			nb = 9'd1;
		else if ({2'b0, cfg.bins_in_use} > 9'(BINS))
			nb = 9'(BINS);
		else
			nb = {2'b0, cfg.bins_in_use};
		nbm1 = BIN_W'(nb - 9'd1);
	end

	always_ff @(posedge clk) begin
		lo_bin <= (lo_pos > IP_W'(nbm1)) ? nbm1 : BIN_W'(lo_pos);
		hi_bin <= (hi_pos > (IP_W+1)'(nbm1)) ? nbm1 : BIN_W'(hi_pos);
		w_hi   <= {1'b0, wh};
		w_lo   <= (ijh_pkg::W_W'(1) << ijh_pkg::FRAC_BITS) - {1'b0, wh};
	end
endmodule

// ----- hdl/ijh_rmw.sv -----
// One histogram memory with saturating read-modify-write, forwarding and clear port.
// Depends on ijh_pkg.
`timescale 1ns / 1ps
module ijh_rmw #(
	parameter int DEPTH = ijh_pkg::BINS_DEF,
	parameter int DW    = ijh_pkg::MW,
	parameter int IW    = ijh_pkg::W_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ijh_pkg::rmw_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [IW-1:0]            inc,
	input  logic [$clog2(DEPTH)-1:0] clr_addr,
	output logic [DW-1:0]            rd_data
);
	localparam int AW = $clog2(DEPTH);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] dout;
	logic [AW-1:0] addr_s1;
	logic [IW-1:0] inc_s1;
	logic          fwd_s1;
	logic [DW-1:0] fwd_data_s1;
	logic          act_s1;
	logic [DW:0]   sum;
	logic          we;
	logic [AW-1:0] wa;
	logic [DW-1:0] wd;

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en)
			dout <= mem[addr];
	end

	// A write issued in the read cycle to the same entry is forwarded.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			addr_s1     <= addr;
			inc_s1      <= inc;
			fwd_s1      <= we && (wa == addr);
			fwd_data_s1 <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= ctl.rd_en && ctl.upd;
		end
	end

	assign rd_data = fwd_s1 ? fwd_data_s1 : dout;
	assign sum     = {1'b0, rd_data} + (DW+1)'(inc_s1);
	assign we      = ctl.clr_en || act_s1;
	assign wa      = ctl.clr_en ? clr_addr : addr_s1;
	assign wd      = ctl.clr_en ? '0 : (sum[DW] ? '1 : sum[DW-1:0]);
endmodule

// ----- hdl/interp_joint_histogram_core.sv -----
// Top level of the linear partial-volume joint histogram core.
// Depends on ijh_pkg, ijh_if, ijh_cfg, ijh_locate, ijh_rmw and the assertion header.
//
// Usage: words enter on the pix channel and are taken when valid and ready are both
// high. Opcode accumulate adds one pixel pair, read returns one joint entry with
// both marginal entries and the pixel count on the res channel, clear zeroes all.
// The block works on one word at a time: an accumulate runs two locate stages, one weight
// product stage, then four read-modify-writes of the joint memory through its single
// port, which set the accumulate rate; a read result passes the memory output register
// and then the output register; a clear zeroes one joint entry per cycle, BINS*BINS in all.
// Results sit in an output register; while it waits on a stalled receiver, further
// accumulate and clear words are still taken, and a read waits in its data cycle
// until the register frees.
// After reset the same clearing pass as a clear runs with ready low; configuration
// writes are taken at any time but must only be made idle.
// Registers: 0 min_intensity, 1 bin_scale, 2 bins_in_use at byte addresses 0, 4, 8.
`timescale 1ns / 1ps
module interp_joint_histogram_core #(
	parameter int BINS = ijh_pkg::BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ijh_in_if.sink                      pix,
	ijh_out_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ijh_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	`include "interp_joint_histogram_core_assert.svh"

	localparam int BIN_W = $clog2(BINS);
	localparam int JD    = BINS * BINS;
	localparam int JA_W  = $clog2(JD);
	localparam logic [ijh_pkg::CW-1:0] CNT_MAX = ijh_pkg::CW'(1) << ijh_pkg::COUNT_BITS;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOC  = 3'd1;
	localparam logic [2:0] ST_PROD = 3'd2;
	localparam logic [2:0] ST_STEP = 3'd3;
	localparam logic [2:0] ST_RDW  = 3'd4;
	localparam logic [2:0] ST_CLR  = 3'd5;

	logic [2:0]              state_q;
	logic [1:0]              step_q;
	logic [JA_W-1:0]         clr_q;
	logic [ijh_pkg::CW-1:0]  cnt_q;
	logic                    va_q;
	logic                    vb_q;
	logic                    res_valid_q;
	logic                    accept;
	logic                    rd_op;
	logic                    res_free;
	ijh_pkg::cfg_t           cfg;

	logic [BIN_W-1:0]        xl, xh, yl, yh;
	logic [ijh_pkg::W_W-1:0] axl, axh, ayl, ayh;
	logic [ijh_pkg::P_W-1:0] p_ll_q, p_hl_q, p_lh_q, p_hh_q;

	ijh_pkg::rmw_ctl_t       j_ctl, ma_ctl, mb_ctl;
	logic [JA_W-1:0]         j_addr;
	logic [BIN_W-1:0]        ma_addr, mb_addr, jx, jy;
	logic [ijh_pkg::P_W-1:0] j_inc;
	logic [ijh_pkg::W_W-1:0] ma_inc, mb_inc;
	logic [ijh_pkg::JW-1:0]  j_rd;
	logic [ijh_pkg::MW-1:0]  ma_rd, mb_rd;
	logic                    clearing;
	logic                    m_clr;

	ijh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);
	assign pready = 1'b1;

	assign pix.ready = (state_q == ST_IDLE);
	assign accept    = pix.valid && pix.ready;
	assign rd_op     = accept && (pix.opcode == ijh_pkg::OP_READ);
	assign res_free  = !res_valid_q || res.ready;
	assign clearing  = (state_q == ST_CLR);
	assign m_clr     = clearing && (clr_q < JA_W'(BINS));

	ijh_locate #(.BINS(BINS)) u_loc_a (
		.clk    (clk),
		.load   (accept),
		.cfg    (cfg),
		.sample (pix.sample_a),
		.lo_bin (xl),
		.hi_bin (xh),
		.w_lo   (axl),
		.w_hi   (axh)
	);

	ijh_locate #(.BINS(BINS)) u_loc_b (
		.clk    (clk),
		.load   (accept),
		.cfg    (cfg),
		.sample (pix.sample_b),
		.lo_bin (yl),
		.hi_bin (yh),
		.w_lo   (ayl),
		.w_hi   (ayh)
	);

	// Joint weight products, one register stage ahead of the accumulate steps.
	always_ff @(posedge clk) begin
		p_ll_q <= ijh_pkg::P_W'(axl) * ijh_pkg::P_W'(ayl);
		p_hl_q <= ijh_pkg::P_W'(axh) * ijh_pkg::P_W'(ayl);
		p_lh_q <= ijh_pkg::P_W'(axl) * ijh_pkg::P_W'(ayh);
		p_hh_q <= ijh_pkg::P_W'(axh) * ijh_pkg::P_W'(ayh);
	end

	// Memory access selection: the four joint corners go one per step, the two
	// marginal neighbors of each axis in the first two steps. A read op reads all
	// three memories in its accept cycle.
	always_comb begin
		unique case (step_q)
			2'd0: begin jx = xl; jy = yl; j_inc = p_ll_q; end
			2'd1: begin jx = xh; jy = yl; j_inc = p_hl_q; end
			2'd2: begin jx = xl; jy = yh; j_inc = p_lh_q; end
			default: begin jx = xh; jy = yh; j_inc = p_hh_q; end
		endcase
		ma_inc = step_q[0] ? axh : axl;
		mb_inc = step_q[0] ? ayh : ayl;
		if (state_q == ST_STEP) begin
			j_addr  = JA_W'(jy) * JA_W'(BINS) + JA_W'(jx);
			ma_addr = step_q[0] ? xh : xl;
			mb_addr = step_q[0] ? yh : yl;
		end else begin
			j_addr  = JA_W'(BIN_W'(pix.read_bin_b)) * JA_W'(BINS)
				+ JA_W'(BIN_W'(pix.read_bin_a));
			ma_addr = BIN_W'(pix.read_bin_a);
			mb_addr = BIN_W'(pix.read_bin_b);
		end
		j_ctl.rd_en  = rd_op || (state_q == ST_STEP);
		j_ctl.upd    = (state_q == ST_STEP);
		j_ctl.clr_en = clearing;
		ma_ctl.rd_en  = rd_op || ((state_q == ST_STEP) && !step_q[1]);
		ma_ctl.upd    = (state_q == ST_STEP);
		ma_ctl.clr_en = m_clr;
		mb_ctl        = ma_ctl;
	end

	ijh_rmw #(.DEPTH(JD), .DW(ijh_pkg::JW), .IW(ijh_pkg::P_W)) u_joint (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (j_ctl),
		.addr     (j_addr),
		.inc      (j_inc),
		.clr_addr (clr_q),
		.rd_data  (j_rd)
	);

	ijh_rmw #(.DEPTH(BINS), .DW(ijh_pkg::MW), .IW(ijh_pkg::W_W)) u_marg_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ma_ctl),
		.addr     (ma_addr),
		.inc      (ma_inc),
		.clr_addr (clr_q[BIN_W-1:0]),
		.rd_data  (ma_rd)
	);

	ijh_rmw #(.DEPTH(BINS), .DW(ijh_pkg::MW), .IW(ijh_pkg::W_W)) u_marg_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mb_ctl),
		.addr     (mb_addr),
		.inc      (mb_inc),
		.clr_addr (clr_q[BIN_W-1:0]),
		.rd_data  (mb_rd)
	);

	// Sequencer, pair counter and clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			step_q  <= '0;
			clr_q   <= '0;
			cnt_q   <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (pix.opcode == ijh_pkg::OP_ACC) begin
							state_q <= ST_LOC;
						end else if (pix.opcode == ijh_pkg::OP_READ) begin
							state_q <= ST_RDW;
							va_q    <= 32'(pix.read_bin_a) < BINS;
							vb_q    <= 32'(pix.read_bin_b) < BINS;
						end else if (pix.opcode == ijh_pkg::OP_CLEAR) begin
							state_q <= ST_CLR;
							clr_q   <= '0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LOC:  state_q <= ST_PROD;
				ST_PROD: begin
					state_q <= ST_STEP;
					step_q  <= '0;
				end
				ST_STEP: begin
					if (step_q == 2'd0 && cnt_q < CNT_MAX)
						cnt_q <= cnt_q + ijh_pkg::CW'(1);
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3)
						state_q <= ST_IDLE;
				end
				ST_RDW: begin
					if (res_free)
						state_q <= ST_IDLE;
				end
				ST_CLR: begin
					cnt_q <= '0;
					clr_q <= clr_q + JA_W'(1);
					if (clr_q == JA_W'(JD - 1))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register; a read result loads as soon as the register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_RDW && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RDW && res_free) begin
			res.joint_sum      <= (va_q && vb_q) ? j_rd : '0;
			res.marginal_a_sum <= va_q ? ma_rd : '0;
			res.marginal_b_sum <= vb_q ? mb_rd : '0;
			res.pixel_total    <= cnt_q;
		end
	end

	assign res.valid = res_valid_q;

	`IJH_ASSERT_NOW(a_clr_blocks_input, state_q == ST_CLR, !pix.ready, "input taken during clear")
	`IJH_ASSERT_NEXT(a_step_holds, (state_q == ST_STEP) && (step_q != 2'd3), state_q == ST_STEP, "accumulate steps cut short")
	`IJH_ASSERT_NEXT(a_result_from_read, !res_valid_q && (state_q != ST_RDW), !res_valid_q, "result without read")
	`IJH_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_MAX, "pair count beyond saturation")
endmodule

// ----- dv/tb_interp_joint_histogram_core.sv -----
// Self-checking testbench of the linear partial-volume joint histogram core.
// Depends on ijh_pkg and the channel interfaces in ijh_if; drives the block by plain tasks
// and checks every read result against a bit-true histogram mirror held in a scoreboard.
`timescale 1ns / 1ps
module tb_interp_joint_histogram_core;

	localparam int NBINS       = ijh_pkg::BINS_DEF;
	localparam int WD_LIMIT    = 20000;
	localparam int DRAIN_WAIT  = 4300;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_ITEMS  = 80;

	// Opcode with no function; the block must ignore it.
	localparam logic [ijh_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [ijh_pkg::OP_W-1:0]        opcode;
		logic [ijh_pkg::SAMPLE_BITS-1:0] sample_a;
		logic [ijh_pkg::SAMPLE_BITS-1:0] sample_b;
		logic [ijh_pkg::RB_W-1:0]        read_bin_a;
		logic [ijh_pkg::RB_W-1:0]        read_bin_b;
	} pix_word_t;

	typedef struct {
		logic [ijh_pkg::JW-1:0] joint_sum;
		logic [ijh_pkg::MW-1:0] marginal_a_sum;
		logic [ijh_pkg::MW-1:0] marginal_b_sum;
		logic [ijh_pkg::CW-1:0] pixel_total;
	} bin_word_t;

	// The scoreboard mirrors all histogram stores and the registers. Accepted accumulate and
	// clear words update the mirror; a read pushes the expected bin word for the result side.
	class hist_scoreboard;
		logic [ijh_pkg::JW-1:0]          joint_mirror [NBINS*NBINS];
		logic [ijh_pkg::MW-1:0]          marg_a_mirror [NBINS];
		logic [ijh_pkg::MW-1:0]          marg_b_mirror [NBINS];
		logic [ijh_pkg::CW-1:0]          pairs_seen;
		logic [ijh_pkg::SAMPLE_BITS-1:0] min_int;
		logic [ijh_pkg::SCALE_W-1:0]     scale;
		logic [ijh_pkg::NB_W-1:0]        nbins;
		bin_word_t                       pending_bins [$];
		int                              errors;
		int                              reads_checked;
		int                              pairs_added;

		function new();
			errors = 0;
			reads_checked = 0;
			pairs_added = 0;
			min_int = '0;
			scale = 32'd16777216;
			nbins = 7'd64;
			wipe();
		endfunction

		function void wipe();
			foreach (joint_mirror[i]) joint_mirror[i] = '0;
			foreach (marg_a_mirror[i]) marg_a_mirror[i] = '0;
			foreach (marg_b_mirror[i]) marg_b_mirror[i] = '0;
			pairs_seen = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				ijh_pkg::REG_MIN_INTENSITY: min_int = value[ijh_pkg::SAMPLE_BITS-1:0];
				ijh_pkg::REG_BIN_SCALE:     scale = value;
				ijh_pkg::REG_BINS_IN_USE:   nbins = value[ijh_pkg::NB_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_bins.size();
		endfunction

		// Fractional bin position of one sample: neighbour bins and their linear weights.
		function void bin_position(input logic [ijh_pkg::SAMPLE_BITS-1:0] sample,
				input int nb, output int lo_bin, output int hi_bin,
				output longint unsigned w_lo, output longint unsigned w_hi);
			longint          diff;
			longint unsigned mag;
			longint unsigned fmask;
			longint unsigned fr;
			longint          lo;
			longint          hi;
			fmask = (64'd1 << ijh_pkg::POS_FRAC) - 1;
			diff = longint'(sample) - longint'(min_int);
			mag = longint'(diff < 0 ? -diff : diff) * longint'(scale);
			if (diff >= 0) begin
				lo = longint'(mag >> ijh_pkg::POS_FRAC);
				fr = mag & fmask;
			end else begin
				// Floor goes toward minus infinity, so the fraction stays in [0,1).
				lo = -longint'((mag + fmask) >> ijh_pkg::POS_FRAC);
				fr = ((64'd1 << ijh_pkg::POS_FRAC) - (mag & fmask)) & fmask;
			end
			w_hi = fr >> (ijh_pkg::POS_FRAC - ijh_pkg::FRAC_BITS);
			w_lo = (64'd1 << ijh_pkg::FRAC_BITS) - w_hi;
			hi = lo + 1;
			if (lo < 0) lo = 0; else if (lo > nb - 1) lo = nb - 1;
			if (hi < 0) hi = 0; else if (hi > nb - 1) hi = nb - 1;
			lo_bin = int'(lo);
			hi_bin = int'(hi);
		endfunction

		function longint unsigned sat_sum(longint unsigned a, longint unsigned b,
				longint unsigned top);
			return (a + b > top) ? top : a + b;
		endfunction

		function void add_joint(int x, int y, longint unsigned w);
			longint unsigned top;
			top = (64'd1 << ijh_pkg::JW) - 1;
			joint_mirror[x + y*NBINS] = sat_sum(joint_mirror[x + y*NBINS], w, top);
		endfunction

		function void note_word(pix_word_t w);
			int              nb;
			int              xl, xh, yl, yh;
			longint unsigned axl, axh, ayl, ayh;
			longint unsigned mtop;
			bin_word_t       r;
			mtop = (64'd1 << ijh_pkg::MW) - 1;
			case (w.opcode)
				ijh_pkg::OP_ACC: begin
					nb = int'(nbins);
					if (nb < 1) nb = 1;
					if (nb > NBINS) nb = NBINS;
					bin_position(w.sample_a, nb, xl, xh, axl, axh);
					bin_position(w.sample_b, nb, yl, yh, ayl, ayh);
					// Colliding neighbours simply add twice into the same entry.
					add_joint(xl, yl, axl * ayl);
					add_joint(xh, yl, axh * ayl);
					add_joint(xl, yh, axl * ayh);
					add_joint(xh, yh, axh * ayh);
					marg_a_mirror[xl] = sat_sum(marg_a_mirror[xl], axl, mtop);
					marg_a_mirror[xh] = sat_sum(marg_a_mirror[xh], axh, mtop);
					marg_b_mirror[yl] = sat_sum(marg_b_mirror[yl], ayl, mtop);
					marg_b_mirror[yh] = sat_sum(marg_b_mirror[yh], ayh, mtop);
					if (pairs_seen < (1 << ijh_pkg::COUNT_BITS)) pairs_seen++;
					pairs_added++;
				end
				ijh_pkg::OP_READ: begin
					r.joint_sum = joint_mirror[w.read_bin_a + w.read_bin_b*NBINS];
					r.marginal_a_sum = marg_a_mirror[w.read_bin_a];
					r.marginal_b_sum = marg_b_mirror[w.read_bin_b];
					r.pixel_total = pairs_seen;
					pending_bins.push_back(r);
				end
				ijh_pkg::OP_CLEAR: wipe();
				default: ;
			endcase
		endfunction

		function void check_word(bin_word_t got);
			bin_word_t want;
			if (pending_bins.size() == 0) begin
				$error("result word with no read outstanding");
				errors++;
				return;
			end
			want = pending_bins.pop_front();
			reads_checked++;
			if (got.joint_sum !== want.joint_sum) begin
				$error("joint_sum expected %0d actual %0d", want.joint_sum, got.joint_sum);
				errors++;
			end
			if (got.marginal_a_sum !== want.marginal_a_sum) begin
				$error("marginal_a_sum expected %0d actual %0d",
					want.marginal_a_sum, got.marginal_a_sum);
				errors++;
			end
			if (got.marginal_b_sum !== want.marginal_b_sum) begin
				$error("marginal_b_sum expected %0d actual %0d",
					want.marginal_b_sum, got.marginal_b_sum);
				errors++;
			end
			if (got.pixel_total !== want.pixel_total) begin
				$error("pixel_total expected %0d actual %0d", want.pixel_total, got.pixel_total);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [ijh_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	ijh_in_if  pix ();
	ijh_out_if res ();

	hist_scoreboard sb;

	// Idle percentages of both sides, and the one long receiver hold-off.
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_req;
	int  idle_cycles;

	interp_joint_histogram_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix.sink),
		.res     (res.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Monitor: every accepted input word feeds the scoreboard, every accepted result word is
	// checked against the oldest pending read.
	always @(posedge clk) begin
		pix_word_t w;
		bin_word_t r;
		if (arst_n && pix.valid && pix.ready) begin
			w.opcode = pix.opcode;
			w.sample_a = pix.sample_a;
			w.sample_b = pix.sample_b;
			w.read_bin_a = pix.read_bin_a;
			w.read_bin_b = pix.read_bin_b;
			sb.note_word(w);
		end
		if (arst_n && res.valid && res.ready) begin
			r.joint_sum = res.joint_sum;
			r.marginal_a_sum = res.marginal_a_sum;
			r.marginal_b_sum = res.marginal_b_sum;
			r.pixel_total = res.pixel_total;
			sb.check_word(r);
		end
	end

	// Watchdog: counts cycles without any handshake on either channel or the register port.
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: ready changes on the falling edge. A hold-off request keeps ready low for a
	// long stretch so the output register fills and a later read backs up the block's input.
	initial begin
		int hold;
		hold = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold == 0) hold = HOLD_CYCLES;
			if (hold > 0) begin
				hold--;
				if (hold == 0) hold_req = 1'b0;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one word; returns at the falling edge after its acceptance.
	task automatic send_word(pix_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.opcode <= w.opcode;
		pix.sample_a <= w.sample_a;
		pix.sample_b <= w.sample_b;
		pix.read_bin_a <= w.read_bin_a;
		pix.read_bin_b <= w.read_bin_b;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_op(logic [ijh_pkg::OP_W-1:0] op, int sa, int sb_val, int ra, int rb);
		pix_word_t w;
		w.opcode = op;
		w.sample_a = sa[ijh_pkg::SAMPLE_BITS-1:0];
		w.sample_b = sb_val[ijh_pkg::SAMPLE_BITS-1:0];
		w.read_bin_a = ra[ijh_pkg::RB_W-1:0];
		w.read_bin_b = rb[ijh_pkg::RB_W-1:0];
		send_word(w);
	endtask

	// Register write over the APB-style port: setup cycle, then access cycle. The port is
	// left selected; the caller releases it after its last write.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ijh_pkg::PADDR_W'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, value);
		@(negedge clk);
	endtask

	// Wait for every read to return, then long enough for a clear to finish, since
	// accumulate and clear words leave nothing behind to wait on.
	task automatic drain_block();
		pix.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic configure(int mn, logic [31:0] sc, int nb);
		drain_block();
		write_reg(ijh_pkg::REG_MIN_INTENSITY, 32'(mn));
		write_reg(ijh_pkg::REG_BIN_SCALE, sc);
		write_reg(ijh_pkg::REG_BINS_IN_USE, 32'(nb));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Samples mostly land around the mapped range so that real bins get filled; the rest
	// are drawn from the whole input range.
	function automatic int pick_sample();
		longint span;
		int     nb;
		nb = int'(sb.nbins);
		if (nb < 1) nb = 1;
		if (nb > NBINS) nb = NBINS;
		if (sb.scale == 0 || $urandom_range(9) < 3) return $urandom_range(65535);
		span = ((longint'(nb) + 1) << ijh_pkg::POS_FRAC) / longint'(sb.scale) + 2;
		if (span > 65535) span = 65535;
		return (int'(sb.min_int) + $urandom_range(int'(span)) - 1) & 16'hFFFF;
	endfunction

	task automatic random_items(int count);
		int kind;
		int nb;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			nb = int'(sb.nbins);
			if (nb < 1) nb = 1;
			if (nb > NBINS) nb = NBINS;
			if (kind < 68)
				send_op(ijh_pkg::OP_ACC, pick_sample(), pick_sample(), $urandom_range(63),
					$urandom_range(63));
			else if (kind < 94) begin
				if ($urandom_range(1))
					send_op(ijh_pkg::OP_READ, $urandom_range(65535), $urandom_range(65535),
						$urandom_range(nb - 1), $urandom_range(nb - 1));
				else
					send_op(ijh_pkg::OP_READ, $urandom_range(65535), $urandom_range(65535),
						$urandom_range(63), $urandom_range(63));
			end else if (kind < 97)
				send_op(ijh_pkg::OP_CLEAR, $urandom_range(65535), $urandom_range(65535),
					$urandom_range(63), $urandom_range(63));
			else
				send_op(OP_UNUSED, $urandom_range(65535), $urandom_range(65535),
					$urandom_range(63), $urandom_range(63));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix.valid = 1'b0;
		pix.opcode = ijh_pkg::OP_ACC;
		pix.sample_a = '0;
		pix.sample_b = '0;
		pix.read_bin_a = '0;
		pix.read_bin_b = '0;
		hold_req = 1'b0;
		idle_cycles = 0;
		send_idle_pct = 35;
		recv_idle_pct = 46;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings, written back explicitly.
		configure(0, 32'd16777216, 64);
		send_op(ijh_pkg::OP_READ, 0, 0, 0, 0);
		send_op(ijh_pkg::OP_ACC, 0, 0, 0, 0);
		send_op(ijh_pkg::OP_ACC, 65535, 65535, 63, 63);
		send_op(ijh_pkg::OP_ACC, 0, 65535, 0, 0);
		send_op(ijh_pkg::OP_ACC, 62, 63, 0, 0);
		send_op(ijh_pkg::OP_READ, 0, 0, 0, 0);
		send_op(ijh_pkg::OP_READ, 0, 0, 63, 63);
		send_op(ijh_pkg::OP_READ, 0, 0, 0, 63);
		send_op(ijh_pkg::OP_READ, 0, 0, 62, 63);
		send_op(OP_UNUSED, 12345, 54321, 1, 2);
		send_op(ijh_pkg::OP_READ, 0, 0, 1, 0);
		send_op(ijh_pkg::OP_CLEAR, 0, 0, 0, 0);
		send_op(ijh_pkg::OP_READ, 0, 0, 63, 63);
		// A fractional position: half a bin per unit puts every odd sample halfway.
		configure(10, 32'd8388608, 64);
		send_op(ijh_pkg::OP_ACC, 11, 13, 0, 0);
		send_op(ijh_pkg::OP_ACC, 9, 0, 0, 0);
		send_op(ijh_pkg::OP_READ, 0, 0, 0, 1);
		send_op(ijh_pkg::OP_READ, 0, 0, 0, 0);
		// Negative positions with a fractional scale, and a single bin in use.
		configure(65535, 32'hFFFFFFFF, 1);
		send_op(ijh_pkg::OP_ACC, 65534, 0, 0, 0);
		send_op(ijh_pkg::OP_ACC, 65535, 65535, 0, 0);
		send_op(ijh_pkg::OP_READ, 0, 0, 0, 0);
		send_op(ijh_pkg::OP_READ, 0, 0, 1, 0);

		// Random phase 1: sender and receiver both idle, with one long receiver hold-off.
		configure(0, 32'd16777216, 64);
		hold_req = 1'b1;
		random_items(RAND_ITEMS);
		configure($urandom_range(4000), 32'($urandom_range(1 << 16, 1 << 20)), 64);
		random_items(RAND_ITEMS);

		// Random phase 2: roles swapped, with zero bins (acts as one) and an oversize count.
		send_idle_pct = 46;
		recv_idle_pct = 35;
		configure($urandom_range(65535), $urandom, 0);
		random_items(RAND_ITEMS);
		configure($urandom_range(1000, 3000), 32'd262144, 127);
		random_items(RAND_ITEMS);

		// Random phase 3: no idling on either side, random bin count.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure($urandom_range(2000), 32'($urandom_range(1 << 16, 1 << 26)),
			$urandom_range(2, 63));
		random_items(RAND_ITEMS);

		drain_block();
		$display("Covered %0d accumulated pixel pairs and %0d checked reads over eight settings,",
			sb.pairs_added, sb.reads_checked);
		$display("including clears, ignored opcodes, negative positions and clamped bins.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ijh_pkg.sv
hdl/ijh_if.sv
hdl/ijh_cfg.sv
hdl/ijh_locate.sv
hdl/ijh_rmw.sv
hdl/interp_joint_histogram_core.sv
dv/tb_interp_joint_histogram_core.sv
